// ===== rtl/pixel_level_balance_color_correct_macros.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef PIXEL_LEVEL_BALANCE_COLOR_CORRECT_MACROS_SVH
`define PIXEL_LEVEL_BALANCE_COLOR_CORRECT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PLBCC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PLBCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/plbcc_pkg.sv =====
`default_nettype none
package plbcc_pkg;

    localparam int PIX_W          = 8;
    localparam int GAIN_W         = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int NUM_LANES      = 3;

    // divider: PIX_W quotient bits, DIV_BITS per stage
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = PIX_W / DIV_BITS;

    // pipeline stage positions
    localparam int STG_LEVEL  = 0;
    localparam int STG_DIV0   = 1;
    localparam int STG_GAIN   = STG_DIV0 + DIV_STAGES;
    localparam int STG_MULT   = STG_GAIN + 1;
    localparam int STG_OUT    = STG_MULT + 1;
    localparam int NUM_STAGES = STG_OUT + 1;

    typedef logic [NUM_STAGES-1:0] stage_en_t;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_GAIN  = 2'd3;

    localparam logic [PIX_W-1:0]  RST_LOW_LEVEL  = 8'd5;
    localparam logic [PIX_W-1:0]  RST_HIGH_LEVEL = 8'd250;
    localparam logic [GAIN_W-1:0] RST_RED_GAIN   = 16'd4710;
    localparam logic [GAIN_W-1:0] RST_BLUE_GAIN  = 16'd3562;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1 << GAIN_FRAC_BITS);

    // color matrix, numerators over 2^CCM_SHIFT
    localparam int COEF_W    = 12;
    localparam int PROD_W    = PIX_W + 1 + COEF_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int CCM_SHIFT = 9;

    localparam logic signed [COEF_W-1:0] CCM_COEF [NUM_LANES][NUM_LANES] = '{
        '{ 12'sd860, -12'sd253, -12'sd95  },
        '{-12'sd109,  12'sd928, -12'sd307 },
        '{ 12'sd20,  -12'sd290,  12'sd782 }
    };

endpackage
`default_nettype wire

// ===== rtl/plbcc_lane.sv =====
`default_nettype none
module plbcc_lane
(
    input  wire logic                              clk,
    input  wire plbcc_pkg::stage_en_t              en,
    input  wire logic [plbcc_pkg::PIX_W-1:0]       pix,
    input  wire logic [plbcc_pkg::PIX_W-1:0]       low_level,
    input  wire logic [plbcc_pkg::PIX_W-1:0]       high_level,
    input  wire logic [plbcc_pkg::GAIN_W-1:0]      gain,
    output logic      [plbcc_pkg::PIX_W-1:0]       value
);

    typedef enum logic [1:0] {LVL_ZERO, LVL_FULL, LVL_DIV} lvl_mode_t;

    localparam int PW   = plbcc_pkg::PIX_W;
    localparam int NDS  = plbcc_pkg::DIV_STAGES;
    localparam int PRW  = plbcc_pkg::PIX_W + plbcc_pkg::GAIN_W;

    // level stage
    lvl_mode_t         mode_reg,  mode_next;
    logic [PW-1:0]     num_reg,   num_next;
    logic [PW-1:0]     den_reg,   den_next;

    always_comb
    begin
        num_next = pix - low_level;
        den_next = high_level - low_level;
        if (pix > low_level && pix < high_level)
        begin
            mode_next = LVL_DIV;
        end
        else if (pix <= low_level)
        begin
            mode_next = LVL_ZERO;
        end
        else
        begin
            mode_next = LVL_FULL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[plbcc_pkg::STG_LEVEL])
        begin
            mode_reg <= mode_next;
            num_reg  <= num_next;
            den_reg  <= den_next;
        end
    end

    // restoring divider: floor(num * 2^PW / den), num < den when dividing
    logic [PW-1:0]  rem_reg  [NDS];
    logic [PW-1:0]  quo_reg  [NDS];
    logic [PW-1:0]  dv_reg   [NDS];
    lvl_mode_t      md_reg   [NDS];
    logic [PW-1:0]  rem_next [NDS];
    logic [PW-1:0]  quo_next [NDS];

    // what each divider stage starts from
    logic [PW-1:0]  rem_in   [NDS];
    logic [PW-1:0]  quo_in   [NDS];
    logic [PW-1:0]  den_in   [NDS];
    lvl_mode_t      md_in    [NDS];

    always_comb
    begin
        rem_in[0] = num_reg;
        quo_in[0] = '0;
        den_in[0] = den_reg;
        md_in[0]  = mode_reg;
        for (int k = 1; k < NDS; k++)
        begin
            rem_in[k] = rem_reg[k-1];
            quo_in[k] = quo_reg[k-1];
            den_in[k] = dv_reg[k-1];
            md_in[k]  = md_reg[k-1];
        end
    end

    always_comb
    begin
        logic [PW:0]   r9;
        logic [PW-1:0] rem_w;
        logic [PW-1:0] quo_w;
        logic [PW-1:0] den_w;
        for (int k = 0; k < NDS; k++)
        begin
            rem_w = rem_in[k];
            quo_w = quo_in[k];
            den_w = den_in[k];
            for (int j = 0; j < plbcc_pkg::DIV_BITS; j++)
            begin
                r9 = {rem_w, 1'b0};
                if (r9 >= {1'b0, den_w})
                begin
                    r9    = r9 - {1'b0, den_w};
                    quo_w = {quo_w[PW-2:0], 1'b1};
                end
                else
                begin
                    quo_w = {quo_w[PW-2:0], 1'b0};
                end
                rem_w = r9[PW-1:0];
            end
            rem_next[k] = rem_w;
            quo_next[k] = quo_w;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NDS; k++)
        begin
            if (en[plbcc_pkg::STG_DIV0 + k])
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                dv_reg[k]  <= den_in[k];
                md_reg[k]  <= md_in[k];
            end
        end
    end

    // white balance gain
    logic [PW-1:0]  lvl;
    logic [PRW-1:0] prod;
    logic [PRW-1:0] prod_sh;
    logic [PW-1:0]  value_reg, value_next;

    always_comb
    begin
        case (md_reg[NDS-1])
            LVL_ZERO: lvl = '0;
            LVL_FULL: lvl = '1;
            LVL_DIV:  lvl = quo_reg[NDS-1];
            default:  lvl = '1;
        endcase
        prod    = PRW'(lvl) * PRW'(gain);
        prod_sh = prod >> plbcc_pkg::GAIN_FRAC_BITS;
        value_next = (|prod_sh[PRW-1:PW]) ? '1 : prod_sh[PW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[plbcc_pkg::STG_GAIN])
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule
`default_nettype wire

// ===== rtl/plbcc_ccm.sv =====
`default_nettype none
module plbcc_ccm
(
    input  wire logic                                                   clk,
    input  wire plbcc_pkg::stage_en_t                                   en,
    input  wire logic [plbcc_pkg::NUM_LANES-1:0][plbcc_pkg::PIX_W-1:0]  chan_in,
    output logic      [plbcc_pkg::NUM_LANES-1:0][plbcc_pkg::PIX_W-1:0]  chan_out
);

    localparam int NL  = plbcc_pkg::NUM_LANES;
    localparam int PW  = plbcc_pkg::PIX_W;
    localparam int PRW = plbcc_pkg::PROD_W;
    localparam int SW  = plbcc_pkg::SUM_W;

    logic signed [PRW-1:0] prod_reg [NL][NL];

    always_ff @(posedge clk)
    begin
        if (en[plbcc_pkg::STG_MULT])
        begin
            for (int o = 0; o < NL; o++)
            begin
                for (int i = 0; i < NL; i++)
                begin
                    prod_reg[o][i] <= PRW'($signed({1'b0, chan_in[i]}))
                                      * PRW'(plbcc_pkg::CCM_COEF[o][i]);
                end
            end
        end
    end

    logic [NL-1:0][PW-1:0] out_reg, out_next;

    always_comb
    begin
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] sh;
        for (int o = 0; o < NL; o++)
        begin
            sum = '0;
            for (int i = 0; i < NL; i++)
            begin
                sum = sum + SW'(prod_reg[o][i]);
            end
            sh = sum >>> plbcc_pkg::CCM_SHIFT;
            if (sum < 0)
            begin
                out_next[o] = '0;
            end
            else if (|sh[SW-1:PW])
            begin
                out_next[o] = '1;
            end
            else
            begin
                out_next[o] = sh[PW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[plbcc_pkg::STG_OUT])
        begin
            out_reg <= out_next;
        end
    end

    assign chan_out = out_reg;

endmodule
`default_nettype wire

// ===== rtl/pixel_level_balance_color_correct.sv =====
// Throughput: one pixel per cycle while out_stall is low; the eight-stage
// pipeline (level, four radix-4 divider stages, gain, matrix products,
// matrix sum) moves whenever the output is not stalled.
// A stalled output holds the pipe; bubbles still close up behind it.
// Reset: async active low; clears valid bits and loads default registers.
`default_nettype none
`include "pixel_level_balance_color_correct_macros.svh"
module pixel_level_balance_color_correct
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [plbcc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [plbcc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [plbcc_pkg::PIX_W-1:0]            red_in,
    input  wire logic [plbcc_pkg::PIX_W-1:0]            green_in,
    input  wire logic [plbcc_pkg::PIX_W-1:0]            blue_in,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic      [plbcc_pkg::PIX_W-1:0]            red_out,
    output logic      [plbcc_pkg::PIX_W-1:0]            green_out,
    output logic      [plbcc_pkg::PIX_W-1:0]            blue_out
);

    localparam int NS = plbcc_pkg::NUM_STAGES;
    localparam int NL = plbcc_pkg::NUM_LANES;
    localparam int PW = plbcc_pkg::PIX_W;

    // config registers
    logic [PW-1:0]                   low_level_reg;
    logic [PW-1:0]                   high_level_reg;
    logic [plbcc_pkg::GAIN_W-1:0]    red_gain_reg;
    logic [plbcc_pkg::GAIN_W-1:0]    blue_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_level_reg  <= plbcc_pkg::RST_LOW_LEVEL;
            high_level_reg <= plbcc_pkg::RST_HIGH_LEVEL;
            red_gain_reg   <= plbcc_pkg::RST_RED_GAIN;
            blue_gain_reg  <= plbcc_pkg::RST_BLUE_GAIN;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                plbcc_pkg::REG_LOW_LEVEL:  low_level_reg  <= cfg_data[PW-1:0];
                plbcc_pkg::REG_HIGH_LEVEL: high_level_reg <= cfg_data[PW-1:0];
                plbcc_pkg::REG_RED_GAIN:   red_gain_reg   <= cfg_data;
                plbcc_pkg::REG_BLUE_GAIN:  blue_gain_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids; a stage loads when empty or when the next one loads
    logic [NS-1:0]        valid_reg, valid_next;
    plbcc_pkg::stage_en_t en;

    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || !out_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            if (en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
            else
            begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = valid_reg[NS-1];

    // per-channel lanes
    logic [NL-1:0][PW-1:0]                lane_pix;
    logic [NL-1:0][plbcc_pkg::GAIN_W-1:0] lane_gain;
    logic [NL-1:0][PW-1:0]                lane_val;
    logic [NL-1:0][PW-1:0]                ccm_out;

    assign lane_pix  = {blue_in, green_in, red_in};
    assign lane_gain = {blue_gain_reg, plbcc_pkg::UNITY_GAIN, red_gain_reg};

    for (genvar l = 0; l < NL; l++)
    begin : g_lane
        plbcc_lane u_lane
        (
            .clk        (clk),
            .en         (en),
            .pix        (lane_pix[l]),
            .low_level  (low_level_reg),
            .high_level (high_level_reg),
            .gain       (lane_gain[l]),
            .value      (lane_val[l])
        );
    end

    plbcc_ccm u_ccm
    (
        .clk      (clk),
        .en       (en),
        .chan_in  (lane_val),
        .chan_out (ccm_out)
    );

    assign red_out   = ccm_out[0];
    assign green_out = ccm_out[1];
    assign blue_out  = ccm_out[2];

    `PLBCC_ASSERT_IMPL(a_full_stall, clk, rst_n, (&valid_reg) && out_stall, in_stall,
        "full pipe with stalled output must stall input")
    `PLBCC_ASSERT_IMPL(a_empty_entry, clk, rst_n, !valid_reg[0], !in_stall,
        "input stalled with empty first stage")
    `PLBCC_ASSERT_NEXT(a_beat_enters, clk, rst_n, in_valid && !in_stall, valid_reg[0],
        "accepted beat missing from first stage")

endmodule
`default_nettype wire

// ===== tb/pixel_correct_checker.sv =====
`timescale 1ns / 100ps
module pixel_correct_checker
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [plbcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [plbcc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                                in_valid,
    input  wire logic                                in_stall,
    input  wire logic [plbcc_pkg::PIX_W-1:0]         red_in,
    input  wire logic [plbcc_pkg::PIX_W-1:0]         green_in,
    input  wire logic [plbcc_pkg::PIX_W-1:0]         blue_in,
    input  wire logic                                out_valid,
    input  wire logic                                out_stall,
    input  wire logic [plbcc_pkg::PIX_W-1:0]         red_out,
    input  wire logic [plbcc_pkg::PIX_W-1:0]         green_out,
    input  wire logic [plbcc_pkg::PIX_W-1:0]         blue_out,
    output int                                       mismatches,
    output int                                       pending
);
    import plbcc_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam int GAIN_SHIFT  = GAIN_FRAC_BITS;
    localparam int MAT_SHIFT   = 9;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    // local copy of the block's registers
    logic [PIX_W-1:0]  low_thr;
    logic [PIX_W-1:0]  high_thr;
    logic [GAIN_W-1:0] red_gain_q;
    logic [GAIN_W-1:0] blue_gain_q;

    pixel_t expected_pixels [$];
    int     err_count = 0;
    int     out_count = 0;

    function automatic logic [PIX_W-1:0] auto_level(input logic [PIX_W-1:0] v);
        int span;
        span = int'(high_thr) - int'(low_thr);
        if (v > low_thr && v < high_thr)
            return PIX_W'((256 * (int'(v) - int'(low_thr))) / span);
        if (v <= low_thr)
            return '0;
        return '1;
    endfunction

    function automatic logic [PIX_W-1:0] apply_gain(input logic [PIX_W-1:0] v,
                                                     input logic [GAIN_W-1:0] gain);
        int prod;
        prod = (int'(v) * int'(gain)) >>> GAIN_SHIFT;
        return (prod > 255) ? '1 : PIX_W'(prod);
    endfunction

    function automatic logic [PIX_W-1:0] matrix_sat(input int sum);
        if (sum < 0)
            return '0;
        if ((sum >>> MAT_SHIFT) > 255)
            return '1;
        return PIX_W'(sum >>> MAT_SHIFT);
    endfunction

    function automatic pixel_t corrected_pixel(input logic [PIX_W-1:0] r,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] b);
        int     lr;
        int     lg;
        int     lb;
        pixel_t p;
        lr = int'(apply_gain(auto_level(r), red_gain_q));
        lg = int'(auto_level(g));
        lb = int'(apply_gain(auto_level(b), blue_gain_q));
        p.red   = matrix_sat( 860 * lr - 253 * lg -  95 * lb);
        p.green = matrix_sat(-109 * lr + 928 * lg - 307 * lb);
        p.blue  = matrix_sat(  20 * lr - 290 * lg + 782 * lb);
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_t want;
        pixel_t got;
        if (!rst_n)
        begin
            low_thr     = RST_LOW_LEVEL;
            high_thr    = RST_HIGH_LEVEL;
            red_gain_q  = RST_RED_GAIN;
            blue_gain_q = RST_BLUE_GAIN;
            expected_pixels.delete();
            pending    <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.red   = red_out;
                got.green = green_out;
                got.blue  = blue_out;
                if (expected_pixels.size() == 0)
                begin
                    if (err_count < MAX_REPORTS)
                        $display("output beat %0d with no pixel pending: got %0d/%0d/%0d",
                                 out_count, got.red, got.green, got.blue);
                    err_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue)
                    begin
                        if (err_count < MAX_REPORTS)
                            $display("beat %0d mismatch: expected r/g/b %0d/%0d/%0d got %0d/%0d/%0d",
                                     out_count, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                        err_count++;
                    end
                end
                out_count++;
            end
            // predict with the registers as they stood before this edge
            if (in_valid && !in_stall)
                expected_pixels.push_back(corrected_pixel(red_in, green_in, blue_in));
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_LOW_LEVEL:  low_thr     = cfg_data[PIX_W-1:0];
                    REG_HIGH_LEVEL: high_thr    = cfg_data[PIX_W-1:0];
                    REG_RED_GAIN:   red_gain_q  = cfg_data[GAIN_W-1:0];
                    REG_BLUE_GAIN:  blue_gain_q = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            pending    <= expected_pixels.size();
            mismatches <= err_count;
        end
    end

endmodule

// ===== tb/pixel_level_balance_color_correct_test.sv =====
`timescale 1ns / 100ps
module pixel_level_balance_color_correct_test;
    import plbcc_pkg::*;

    localparam int LATENCY      = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 6;
    localparam int BLOCKS       = 5;
    localparam int BLOCK_PIXELS = 65;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      red_in    = '0;
    logic [PIX_W-1:0]      green_in  = '0;
    logic [PIX_W-1:0]      blue_in   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [PIX_W-1:0]      red_out;
    logic [PIX_W-1:0]      green_out;
    logic [PIX_W-1:0]      blue_out;

    int mismatches;
    int pending;
    int tx_idle_pct = 22;
    int rx_idle_pct = 81;
    int hold_reqs   = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int cycle_count = 0;

    // thresholds as last written, used to aim random pixels at the edges
    logic [PIX_W-1:0] level_lo = RST_LOW_LEVEL;
    logic [PIX_W-1:0] level_hi = RST_HIGH_LEVEL;

    pixel_level_balance_color_correct uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    pixel_correct_checker pixel_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // output side: random stall, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_reqs != hold_seen)
        begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
    endtask

    task automatic write_config(input logic [PIX_W-1:0] lo, input logic [PIX_W-1:0] hi,
                                input logic [GAIN_W-1:0] rg, input logic [GAIN_W-1:0] bg);
        logic [CFG_DATA_W-1:0] vals [4];
        // junk in the unused upper bits of the 8-bit registers
        vals[REG_LOW_LEVEL]              = CFG_DATA_W'($urandom);
        vals[REG_LOW_LEVEL][PIX_W-1:0]   = lo;
        vals[REG_HIGH_LEVEL]             = CFG_DATA_W'($urandom);
        vals[REG_HIGH_LEVEL][PIX_W-1:0]  = hi;
        vals[REG_RED_GAIN]               = rg;
        vals[REG_BLUE_GAIN]              = bg;
        for (int i = 0; i < 4; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        level_lo = lo;
        level_hi = hi;
    endtask

    task automatic edge_setting(input logic [PIX_W-1:0] lo, input logic [PIX_W-1:0] hi,
                                input logic [GAIN_W-1:0] rg, input logic [GAIN_W-1:0] bg);
        write_config(lo, hi, rg, bg);
        send_pixel(lo, lo + 8'd1, hi);
        send_pixel(hi - 8'd1, 8'hFF, 8'h00);
        drain_pipe();
    endtask

    function automatic logic [PIX_W-1:0] random_level();
        case ($urandom_range(0, 9))
            0: return level_lo;
            1: return level_lo + 8'd1;
            2: return level_hi - 8'd1;
            3: return level_hi;
            4: return 8'h00;
            5: return 8'hFF;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic random_config();
        logic [PIX_W-1:0]  lo;
        logic [PIX_W-1:0]  hi;
        logic [GAIN_W-1:0] rg;
        logic [GAIN_W-1:0] bg;
        case ($urandom_range(0, 9))
            0:
            begin
                lo = PIX_W'($urandom);
                hi = PIX_W'($urandom);
            end
            1:
            begin
                // no value strictly between the thresholds
                lo = PIX_W'($urandom_range(0, 254));
                hi = lo + 8'd1;
            end
            default:
            begin
                lo = PIX_W'($urandom_range(0, 200));
                hi = PIX_W'($urandom_range(lo + 2, 255));
            end
        endcase
        rg = $urandom_range(0, 1) ? GAIN_W'($urandom_range(2048, 8192)) : GAIN_W'($urandom);
        bg = $urandom_range(0, 1) ? GAIN_W'($urandom_range(2048, 8192)) : GAIN_W'($urandom);
        write_config(lo, hi, rg, bg);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds 5 / 250
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd5,   8'd5,   8'd5);
        send_pixel(8'd6,   8'd6,   8'd6);
        send_pixel(8'd249, 8'd249, 8'd249);
        send_pixel(8'd250, 8'd250, 8'd250);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd4,   8'd251, 8'd127);
        send_pixel(8'hAA,  8'h55,  8'hAA);
        send_pixel(8'h55,  8'hAA,  8'h55);
        drain_pipe();

        edge_setting(8'd0,   8'd255, UNITY_GAIN, 16'hFFFF);
        edge_setting(8'd253, 8'd255, 16'h0000,   16'h0000);
        edge_setting(8'd100, 8'd101, 16'hFFFF,   UNITY_GAIN);
        edge_setting(8'd128, 8'd128, 16'h8000,   16'h7FFF);
        edge_setting(8'd200, 8'd50,  16'h5555,   16'hAAAA);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph / 2)
                0:
                begin
                    tx_idle_pct <= 22;
                    rx_idle_pct <= 81;
                end
                1:
                begin
                    tx_idle_pct <= 81;
                    rx_idle_pct <= 22;
                end
                default:
                begin
                    tx_idle_pct <= 0;
                    rx_idle_pct <= 0;
                end
            endcase
            for (int blk = 0; blk < BLOCKS; blk++)
            begin
                random_config();
                // long output hold-off while input keeps coming: pipe fills, input stalls
                if (ph == 4 && blk == 0)
                    hold_reqs <= hold_reqs + 1;
                for (int n = 0; n < BLOCK_PIXELS; n++)
                    send_pixel(random_level(), random_level(), random_level());
                drain_pipe();
            end
        end

        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== pixel_level_balance_color_correct.f =====
+incdir+rtl
rtl/plbcc_pkg.sv
rtl/plbcc_lane.sv
rtl/plbcc_ccm.sv
rtl/pixel_level_balance_color_correct.sv
tb/pixel_correct_checker.sv
tb/pixel_level_balance_color_correct_test.sv
